>>> rtl/qsl_pkg.sv
package qsl_pkg;

    localparam int DEPTH       = 64;
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = IDX_W + 1;
    localparam int STACK_DEPTH = DEPTH;
    localparam int STK_AW      = $clog2(STACK_DEPTH);
    localparam int SP_W        = STK_AW + 1;
    localparam int DATA_W      = 32;
    localparam int ENTRY_W     = 2 * IDX_W;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_POP,
        ST_POP_WAIT,
        ST_PIVOT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_FIN_A,
        ST_FIN_B,
        ST_PUSH_LO,
        ST_PUSH_HI,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

endpackage

>>> rtl/qsl_ram.sv
module qsl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/quicksort_lomuto_sorter.sv
// Collects up to DEPTH signed 32-bit items, one per cycle; the item marked last closes the
// set, and items beyond DEPTH are dropped and flag overflow on every result of that set.
// The set is then sorted in place by Lomuto quicksort, with pending ranges held on a stack
// in RAM, and emitted in ascending order, end_of_run on the final result. The element store
// is a RAM with one write port and a registered read port: each scanned element is read and
// then compared, each swap writes its two entries in turn, and each partitioned range also
// passes through the pop, pivot read, pivot placement and push steps. Each result is read and
// then loaded into the output register once the previous one has been taken. in_ready is low
// from the last item until the final result has been loaded into the output register.
module quicksort_lomuto_sorter
    import qsl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     last,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] sorted_value,
    output logic                     end_of_run,
    output logic                     overflow
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              drop_reg, drop_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [IDX_W-1:0]  lo_reg, lo_next;
    logic [IDX_W-1:0]  hi_reg, hi_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  st_reg, st_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [DATA_W-1:0] pivot_reg, pivot_next;
    logic [DATA_W-1:0] vj_reg, vj_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_value_reg, out_value_next;
    logic              out_eor_reg, out_eor_next;
    logic              out_ovf_reg, out_ovf_next;

    logic              e_we;
    logic [IDX_W-1:0]  e_waddr;
    logic [DATA_W-1:0] e_wdata;
    logic [IDX_W-1:0]  e_raddr;
    logic [DATA_W-1:0] e_rdata;

    logic               s_we;
    logic [STK_AW-1:0]  s_waddr;
    logic [ENTRY_W-1:0] s_wdata;
    logic [STK_AW-1:0]  s_raddr;
    logic [ENTRY_W-1:0] s_rdata;

    logic              full;
    logic              in_acc;
    logic              out_acc;
    logic              le_pivot;
    logic [CNT_W-1:0]  st_wide;
    logic [CNT_W-1:0]  lo_wide;
    logic [CNT_W-1:0]  hi_wide;
    logic [SP_W-1:0]   sp_dec;
    logic              last_k;

    qsl_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_elem_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    qsl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    assign in_ready     = (state_reg == ST_LOAD);
    assign in_acc       = in_valid && in_ready;
    assign out_acc      = out_valid_reg && out_ready;
    assign full         = (count_reg == CNT_W'(DEPTH));
    assign le_pivot     = ($signed(e_rdata) <= $signed(pivot_reg));
    assign st_wide      = {1'b0, st_reg};
    assign lo_wide      = {1'b0, lo_reg};
    assign hi_wide      = {1'b0, hi_reg};
    assign sp_dec       = sp_reg - SP_W'(1);
    assign last_k       = ({1'b0, k_reg} == (count_reg - CNT_W'(1)));

    assign out_valid    = out_valid_reg;
    assign sorted_value = out_value_reg;
    assign end_of_run   = out_eor_reg;
    assign overflow     = out_ovf_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc && last)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                state_next = (count_reg < CNT_W'(2)) ? ST_EMIT_RD : ST_POP;
            end
            ST_POP:
            begin
                state_next = (sp_reg == '0) ? ST_EMIT_RD : ST_POP_WAIT;
            end
            ST_POP_WAIT: state_next = ST_PIVOT;
            ST_PIVOT:    state_next = ST_SCAN_RD;
            ST_SCAN_RD:
            begin
                state_next = (j_reg == hi_reg) ? ST_FIN_A : ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                state_next = le_pivot ? ST_SWAP_A : ST_SCAN_RD;
            end
            ST_SWAP_A:   state_next = ST_SWAP_B;
            ST_SWAP_B:   state_next = ST_SCAN_RD;
            ST_FIN_A:    state_next = ST_FIN_B;
            ST_FIN_B:    state_next = ST_PUSH_LO;
            ST_PUSH_LO:  state_next = ST_PUSH_HI;
            ST_PUSH_HI:  state_next = ST_POP;
            ST_EMIT_RD:
            begin
                if (!out_valid_reg)
                begin
                    state_next = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD:
            begin
                state_next = last_k ? ST_LOAD : ST_EMIT_RD;
            end
            default:     state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        drop_next      = drop_reg;
        sp_next        = sp_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        j_next         = j_reg;
        st_next        = st_reg;
        k_next         = k_reg;
        pivot_next     = pivot_reg;
        vj_next        = vj_reg;
        out_valid_next = out_acc ? 1'b0 : out_valid_reg;
        out_value_next = out_value_reg;
        out_eor_next   = out_eor_reg;
        out_ovf_next   = out_ovf_reg;

        e_we    = 1'b0;
        e_waddr = count_reg[IDX_W-1:0];
        e_wdata = value;
        e_raddr = j_reg;
        s_we    = 1'b0;
        s_waddr = sp_reg[STK_AW-1:0];
        s_wdata = {lo_reg, hi_reg};
        s_raddr = sp_dec[STK_AW-1:0];

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        e_we       = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            ST_INIT:
            begin
                k_next = '0;
                if (count_reg >= CNT_W'(2))
                begin
                    s_we    = 1'b1;
                    s_waddr = '0;
                    s_wdata = {IDX_W'(0), IDX_W'(count_reg - CNT_W'(1))};
                    sp_next = SP_W'(1);
                end
            end
            ST_POP:
            begin
                k_next = '0;
                if (sp_reg != '0)
                begin
                    sp_next = sp_dec;
                end
            end
            ST_POP_WAIT:
            begin
                lo_next = s_rdata[ENTRY_W-1:IDX_W];
                hi_next = s_rdata[IDX_W-1:0];
                e_raddr = s_rdata[IDX_W-1:0];
            end
            ST_PIVOT:
            begin
                pivot_next = e_rdata;
                j_next     = lo_reg;
                st_next    = lo_reg;
            end
            ST_SCAN_RD:
            begin
                e_raddr = (j_reg == hi_reg) ? st_reg : j_reg;
            end
            ST_SCAN_CMP:
            begin
                if (le_pivot)
                begin
                    vj_next = e_rdata;
                    e_raddr = st_reg;
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            ST_SWAP_A:
            begin
                e_we    = 1'b1;
                e_waddr = j_reg;
                e_wdata = e_rdata;
            end
            ST_SWAP_B:
            begin
                e_we    = 1'b1;
                e_waddr = st_reg;
                e_wdata = vj_reg;
                st_next = st_reg + IDX_W'(1);
                j_next  = j_reg + IDX_W'(1);
            end
            ST_FIN_A:
            begin
                e_we    = 1'b1;
                e_waddr = hi_reg;
                e_wdata = e_rdata;
            end
            ST_FIN_B:
            begin
                e_we    = 1'b1;
                e_waddr = st_reg;
                e_wdata = pivot_reg;
            end
            ST_PUSH_LO:
            begin
                if (st_wide > lo_wide + CNT_W'(1))
                begin
                    s_we    = 1'b1;
                    s_wdata = {lo_reg, st_reg - IDX_W'(1)};
                    sp_next = sp_reg + SP_W'(1);
                end
            end
            ST_PUSH_HI:
            begin
                if (st_wide + CNT_W'(1) < hi_wide)
                begin
                    s_we    = 1'b1;
                    s_wdata = {st_reg + IDX_W'(1), hi_reg};
                    sp_next = sp_reg + SP_W'(1);
                end
            end
            ST_EMIT_RD:
            begin
                e_raddr = k_reg;
            end
            ST_EMIT_LD:
            begin
                out_valid_next = 1'b1;
                out_value_next = e_rdata;
                out_eor_next   = last_k;
                out_ovf_next   = drop_reg;
                if (last_k)
                begin
                    count_next = '0;
                    drop_next  = 1'b0;
                    sp_next    = '0;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        j_reg         <= j_next;
        st_reg        <= st_next;
        k_reg         <= k_next;
        pivot_reg     <= pivot_next;
        vj_reg        <= vj_next;
        out_value_reg <= out_value_next;
        out_eor_reg   <= out_eor_next;
        out_ovf_reg   <= out_ovf_next;
    end

endmodule
